@@ sv/htd_pkg.sv @@
// Package for the Huffman tree decoder: field widths, action codes,
// sequencer states and the result struct. Has no dependencies.
package htd_pkg;

    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 32;
    localparam int LCOUNT_W = 9;
    localparam int SYM_W    = 8;
    localparam int LFREQ_W  = 31;
    localparam int FREQ_W   = 32;
    localparam int BYTE_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 2'd0,
        ACT_LEAF   = 2'd1,
        ACT_STREAM = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RDL,
        S_RDR,
        S_FL,
        S_FR,
        S_SUM,
        S_SRD,
        S_SFR,
        S_SCMP,
        S_SINS,
        S_ROOT,
        S_ROOT2,
        S_WRD,
        S_WBIT,
        S_WSYM
    } t_state;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             block_done;
    } t_res;

endpackage

@@ sv/htd_if.sv @@
// Channel interfaces for the Huffman tree decoder (input items and results).
// Depends on htd_pkg for the field widths.
interface htd_in_if;
    logic                           valid;
    logic                           ready;
    logic [htd_pkg::ACTION_W-1:0]   action;
    logic [htd_pkg::COUNT_W-1:0]    symbol_count;
    logic [htd_pkg::LCOUNT_W-1:0]   leaf_count;
    logic [htd_pkg::SYM_W-1:0]      leaf_symbol;
    logic [htd_pkg::LFREQ_W-1:0]    leaf_frequency;
    logic [htd_pkg::BYTE_W-1:0]     stream_byte;

    modport source(output valid, action, symbol_count, leaf_count, leaf_symbol,
                   leaf_frequency, stream_byte, input ready);
    modport sink(input valid, action, symbol_count, leaf_count, leaf_symbol,
                 leaf_frequency, stream_byte, output ready);
endinterface

interface htd_out_if;
    logic                       valid;
    logic                       ready;
    logic [htd_pkg::SYM_W-1:0]  symbol;
    logic                       last;
    logic                       block_done;

    modport source(output valid, symbol, last, block_done, input ready);
    modport sink(input valid, symbol, last, block_done, output ready);
endinterface

@@ sv/htd_ctrl.sv @@
// Sequencer and tree memories of the Huffman tree decoder: leaf loading,
// tree build with one shared adder and comparator, and the bitwise walk.
// Depends on htd_pkg and htd_if.
module htd_ctrl #(
    parameter int MAX_LEAVES = 256,
    parameter int MAX_NODES  = 511
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    htd_in_if.sink               i_in,
    output logic                 o_push_valid,
    output htd_pkg::t_res        o_push,
    input  logic                 i_push_ready
);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int LW  = $clog2(MAX_LEAVES + 1);
    localparam int LAW = $clog2(MAX_LEAVES);
    localparam int CW  = (NW > LW) ? NW : LW;
    localparam int LIM = (MAX_LEAVES < (MAX_NODES + 1) / 2) ? MAX_LEAVES
                                                            : (MAX_NODES + 1) / 2;
    localparam int FW  = htd_pkg::FREQ_W;
    localparam int LCOUNT_W_LOCAL = htd_pkg::LCOUNT_W;
    localparam logic [htd_pkg::COUNT_W-1:0] COUNT_ONE = htd_pkg::COUNT_W'(1);

    // Tree memories.
    logic [FW-1:0]               m_freq [MAX_NODES];
    logic [NW-1:0]               m_lc   [MAX_NODES];
    logic [NW-1:0]               m_rc   [MAX_NODES];
    logic [NW-1:0]               m_ord  [MAX_LEAVES];
    logic [htd_pkg::SYM_W-1:0]   m_sym  [MAX_LEAVES];

    logic                        freq_we, ch_we, ord_we, sym_we, sym_re;
    logic [NW-1:0]               freq_wa, freq_ra, ch_wa, ch_ra, lc_wd, rc_wd, ord_wd;
    logic [FW-1:0]               freq_wd;
    logic [LAW-1:0]              ord_wa, ord_ra, sym_wa, sym_ra;
    logic [htd_pkg::SYM_W-1:0]   sym_wd;
    logic [FW-1:0]               freq_q;
    logic [NW-1:0]               lc_q, rc_q, ord_q;
    logic [htd_pkg::SYM_W-1:0]   sym_q;

    always_ff @(posedge i_clk) begin
        if (freq_we) begin
            m_freq[freq_wa] <= freq_wd;
        end
        if (ch_we) begin
            m_lc[ch_wa] <= lc_wd;
            m_rc[ch_wa] <= rc_wd;
        end
        if (ord_we) begin
            m_ord[ord_wa] <= ord_wd;
        end
        if (sym_we) begin
            m_sym[sym_wa] <= sym_wd;
        end
        freq_q <= m_freq[freq_ra];
        lc_q   <= m_lc[ch_ra];
        rc_q   <= m_rc[ch_ra];
        ord_q  <= m_ord[ord_ra];
        // The symbol read is held while a result waits for the receiver.
        if (sym_re) begin
            sym_q <= m_sym[sym_ra];
        end
    end

    htd_pkg::t_state             r_state, n_state;
    logic [LW-1:0]               r_exp, n_exp, r_loaded, n_loaded;
    logic [LW-1:0]               r_cnt, n_cnt, r_pos, n_pos, r_k, n_k;
    logic [htd_pkg::COUNT_W-1:0] r_left, n_left;
    logic [NW-1:0]               r_root, n_root, r_walk, n_walk, r_next, n_next;
    logic [NW-1:0]               r_l, n_l, r_r, n_r, r_o, n_o;
    logic [FW-1:0]               r_fl, n_fl, r_f, n_f;
    logic [htd_pkg::BYTE_W-1:0]  r_bits, n_bits;
    logic [2:0]                  r_b, n_b;
    logic                        r_pv, n_pv, r_pdone, n_pdone;
    logic [htd_pkg::SYM_W-1:0]   r_psym, n_psym;

    logic                        w_acc;
    logic [LCOUNT_W_LOCAL-1:0]   w_ncl;
    logic [FW:0]                 w_sum;
    logic [FW-1:0]               w_f;
    logic [NW-1:0]               w_wsel, w_child;
    logic                        w_inner, w_stream_ok, w_leaf_ok;

    assign w_acc = i_in.valid && i_in.ready;

    always_comb begin
        w_ncl = i_in.leaf_count;
        if (w_ncl == '0) begin
            w_ncl = LCOUNT_W_LOCAL'(1);
        end else if (w_ncl > LCOUNT_W_LOCAL'(LIM)) begin
            w_ncl = LCOUNT_W_LOCAL'(LIM);
        end
    end

    // The shared adder saturates the parent frequency on carry out.
    assign w_sum       = {1'b0, r_fl} + {1'b0, freq_q};
    assign w_f         = w_sum[FW] ? '1 : w_sum[FW-1:0];
    assign w_wsel      = ({1'b0, r_walk} >= (NW+1)'(MAX_NODES)) ? r_root : r_walk;
    assign w_child     = r_bits[r_b] ? rc_q : lc_q;
    assign w_inner     = CW'(w_child) >= CW'(r_exp);
    assign w_stream_ok = (r_exp != '0) && (r_loaded == r_exp) && (r_left != '0);
    assign w_leaf_ok   = r_loaded < r_exp;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            htd_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_in.action == htd_pkg::ACT_LEAF && w_leaf_ok &&
                        (r_loaded + LW'(1) == r_exp)) begin
                        n_state = htd_pkg::S_INIT;
                    end else if (i_in.action == htd_pkg::ACT_STREAM && w_stream_ok) begin
                        n_state = htd_pkg::S_WRD;
                    end
                end
            end
            htd_pkg::S_INIT: begin
                if (r_k + LW'(1) == r_exp) begin
                    n_state = (r_exp > LW'(1)) ? htd_pkg::S_RDL : htd_pkg::S_ROOT;
                end
            end
            htd_pkg::S_RDL:  n_state = htd_pkg::S_RDR;
            htd_pkg::S_RDR:  n_state = htd_pkg::S_FL;
            htd_pkg::S_FL:   n_state = htd_pkg::S_FR;
            htd_pkg::S_FR:   n_state = htd_pkg::S_SUM;
            htd_pkg::S_SUM: begin
                n_state = (r_cnt == LW'(2)) ? htd_pkg::S_SINS : htd_pkg::S_SRD;
            end
            htd_pkg::S_SRD:  n_state = htd_pkg::S_SFR;
            htd_pkg::S_SFR:  n_state = htd_pkg::S_SCMP;
            htd_pkg::S_SCMP: begin
                if (freq_q < r_f && r_pos != LW'(1)) begin
                    n_state = htd_pkg::S_SRD;
                end else begin
                    n_state = htd_pkg::S_SINS;
                end
            end
            htd_pkg::S_SINS: begin
                n_state = (r_cnt != '0) ? htd_pkg::S_RDL : htd_pkg::S_ROOT;
            end
            htd_pkg::S_ROOT:  n_state = htd_pkg::S_ROOT2;
            htd_pkg::S_ROOT2: n_state = htd_pkg::S_IDLE;
            htd_pkg::S_WRD: begin
                n_state = (r_exp == LW'(1)) ? htd_pkg::S_WSYM : htd_pkg::S_WBIT;
            end
            htd_pkg::S_WBIT: begin
                if (!w_inner) begin
                    n_state = htd_pkg::S_WSYM;
                end else if (r_b == 3'd7) begin
                    n_state = r_pv ? htd_pkg::S_WSYM : htd_pkg::S_IDLE;
                end else begin
                    n_state = htd_pkg::S_WRD;
                end
            end
            htd_pkg::S_WSYM: begin
                // Entered either with a fresh symbol or, at the end of a byte or once the
                // count is met, only to flush the pending result.
                if (!r_pv || i_push_ready) begin
                    if (r_flush) begin
                        n_state = htd_pkg::S_IDLE;
                    end else if (r_b == 3'd7 || r_left == COUNT_ONE) begin
                        n_state = htd_pkg::S_WSYM;
                    end else begin
                        n_state = htd_pkg::S_WRD;
                    end
                end
            end
            default: n_state = htd_pkg::S_IDLE;
        endcase
    end

    logic r_flush, n_flush;

    // Datapath, memory controls and the result push.
    always_comb begin
        n_exp = r_exp;  n_loaded = r_loaded; n_cnt = r_cnt; n_pos = r_pos;
        n_k = r_k;      n_left = r_left;     n_root = r_root; n_walk = r_walk;
        n_next = r_next; n_l = r_l; n_r = r_r; n_o = r_o; n_fl = r_fl; n_f = r_f;
        n_bits = r_bits; n_b = r_b; n_pv = r_pv; n_pdone = r_pdone; n_psym = r_psym;
        n_flush = r_flush;
        freq_we = 1'b0; ch_we = 1'b0; ord_we = 1'b0; sym_we = 1'b0; sym_re = 1'b0;
        freq_wa = '0; freq_ra = '0; freq_wd = '0;
        ch_wa = r_next; ch_ra = w_wsel; lc_wd = r_l; rc_wd = r_r;
        ord_wa = '0; ord_ra = '0; ord_wd = '0;
        sym_wa = r_loaded[LAW-1:0];
        sym_ra = '0;
        sym_wd = i_in.leaf_symbol;
        o_push_valid = 1'b0;
        o_push       = '{symbol: r_psym, last: 1'b0, block_done: r_pdone};
        i_in.ready   = (r_state == htd_pkg::S_IDLE);
        case (r_state)
            htd_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (i_in.action)
                        htd_pkg::ACT_START: begin
                            n_exp    = LW'(w_ncl);
                            n_loaded = '0;
                            n_left   = i_in.symbol_count;
                            n_root   = '0;
                            n_walk   = '0;
                        end
                        htd_pkg::ACT_LEAF: begin
                            if (w_leaf_ok) begin
                                sym_we   = 1'b1;
                                freq_we  = 1'b1;
                                freq_wa  = NW'(r_loaded);
                                freq_wd  = {1'b0, i_in.leaf_frequency};
                                n_loaded = r_loaded + LW'(1);
                                n_k      = '0;
                                n_cnt    = r_exp;
                                n_next   = NW'(r_exp);
                            end
                        end
                        htd_pkg::ACT_STREAM: begin
                            n_bits  = i_in.stream_byte;
                            n_b     = '0;
                            n_flush = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            htd_pkg::S_INIT: begin
                ord_we = 1'b1;
                ord_wa = r_k[LAW-1:0];
                ord_wd = NW'(r_k);
                n_k    = r_k + LW'(1);
            end
            htd_pkg::S_RDL: ord_ra = LAW'(r_cnt - LW'(1));
            htd_pkg::S_RDR: begin
                ord_ra = LAW'(r_cnt - LW'(2));
                n_l    = ord_q;
            end
            htd_pkg::S_FL: begin
                n_r     = ord_q;
                freq_ra = r_l;
            end
            htd_pkg::S_FR: begin
                n_fl    = freq_q;
                freq_ra = r_r;
            end
            htd_pkg::S_SUM: begin
                freq_we = 1'b1;
                freq_wa = r_next;
                freq_wd = w_f;
                ch_we   = 1'b1;
                n_f     = w_f;
                n_cnt   = r_cnt - LW'(2);
                n_pos   = r_cnt - LW'(2);
            end
            htd_pkg::S_SRD: ord_ra = LAW'(r_pos - LW'(1));
            htd_pkg::S_SFR: begin
                n_o     = ord_q;
                freq_ra = ord_q;
            end
            htd_pkg::S_SCMP: begin
                // Entries lighter than the parent shift one place to the rear.
                if (freq_q < r_f) begin
                    ord_we = 1'b1;
                    ord_wa = r_pos[LAW-1:0];
                    ord_wd = r_o;
                    n_pos  = r_pos - LW'(1);
                end
            end
            htd_pkg::S_SINS: begin
                ord_we = 1'b1;
                ord_wa = r_pos[LAW-1:0];
                ord_wd = r_next;
                n_next = r_next + NW'(1);
                n_cnt  = r_cnt + LW'(1);
            end
            htd_pkg::S_ROOT: ord_ra = '0;
            htd_pkg::S_ROOT2: begin
                n_root = ord_q;
                n_walk = ord_q;
            end
            htd_pkg::S_WRD: begin
                ch_ra  = w_wsel;
                sym_ra = '0;
                sym_re = 1'b1;
            end
            htd_pkg::S_WBIT: begin
                if (w_inner) begin
                    n_walk = w_child;
                    if (r_b == 3'd7) begin
                        n_flush = 1'b1;
                    end else begin
                        n_b = r_b + 3'd1;
                    end
                end else begin
                    sym_ra = w_child[LAW-1:0];
                    sym_re = 1'b1;
                    n_walk = r_root;
                end
            end
            htd_pkg::S_WSYM: begin
                o_push_valid = r_pv;
                o_push.last  = r_flush;
                if (!r_pv || i_push_ready) begin
                    if (r_flush) begin
                        n_pv = 1'b0;
                    end else begin
                        n_pv    = 1'b1;
                        n_psym  = sym_q;
                        n_pdone = (r_left == COUNT_ONE);
                        n_left  = r_left - COUNT_ONE;
                        if (r_b == 3'd7 || r_left == COUNT_ONE) begin
                            n_flush = 1'b1;
                        end else begin
                            n_b = r_b + 3'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= htd_pkg::S_IDLE;
            r_exp    <= '0;
            r_loaded <= '0;
            r_left   <= '0;
            r_root   <= '0;
            r_walk   <= '0;
            r_pv     <= 1'b0;
            r_flush  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_exp    <= n_exp;
            r_loaded <= n_loaded;
            r_left   <= n_left;
            r_root   <= n_root;
            r_walk   <= n_walk;
            r_pv     <= n_pv;
            r_flush  <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_next  <= n_next;
        r_l     <= n_l;
        r_r     <= n_r;
        r_o     <= n_o;
        r_fl    <= n_fl;
        r_f     <= n_f;
        r_bits  <= n_bits;
        r_b     <= n_b;
        r_pdone <= n_pdone;
        r_psym  <= n_psym;
    end

endmodule

@@ sv/htd_out_stage.sv @@
// Output register of the Huffman tree decoder: holds one result while the
// receiver stalls. Depends on htd_pkg and htd_if.
module htd_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  htd_pkg::t_res  i_push,
    output logic           o_push_ready,
    htd_out_if.source      o_out
);
    logic          r_valid;
    htd_pkg::t_res r_data;

    assign o_push_ready     = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.symbol     = r_data.symbol;
    assign o_out.last       = r_data.last;
    assign o_out.block_done = r_data.block_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push_valid && o_push_ready) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_valid && o_push_ready) begin
            r_data <= i_push;
        end
    end

endmodule

@@ sv/huffman_tree_decoder.sv @@
// Huffman tree decoder, top level: sequencer with tree memories and the
// output register. Depends on htd_pkg, htd_if, htd_ctrl and htd_out_stage.
//
// Usage: every item on i_in is a start (symbol and leaf counts), a leaf
// (symbol and frequency, heaviest first) or a stream byte. Results on o_out
// carry one decoded symbol each, with last on the final result of an item
// and block_done on the symbol that meets the symbol count.
// After the last leaf the tree is built with one shared adder and
// comparator: the order list is seeded, then each merge reads the two
// lightest entries, fetches their frequencies, writes the parent with
// their sum, compares it with the list entries from the rear and inserts
// it, and at the end the root is fetched from the head of the list.
// A stream byte is walked one code bit at a time, each step waiting for
// the child memory read; each decoded symbol is pushed, the item closes
// with its last result, and a byte stops early once the count is met.
// One item is worked on at a time; i_in.ready is high only between items.
// Reset returns the sequencer to idle and drops the tree and the counts; the
// memories are not cleared, as every entry is written before it is read.
// When the receiver stalls, the output register holds the result and the
// walk waits for it before it hands over the next one.
module huffman_tree_decoder #(
    parameter int MAX_LEAVES = 256,
    parameter int MAX_NODES  = 511
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htd_in_if.sink     i_in,
    htd_out_if.source  o_out
);
    logic          push_valid, push_ready;
    htd_pkg::t_res push;

    htd_ctrl #(
        .MAX_LEAVES (MAX_LEAVES),
        .MAX_NODES  (MAX_NODES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    htd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_out        (o_out)
    );

endmodule

@@ sv/htd_checker.sv @@
// Port checker for the Huffman tree decoder and its bind to the top level.
// Depends only on the top level's ports.
module htd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_symbol,
    input logic       i_out_last,
    input logic       i_out_done
);
    // A result that completes the block must close the transfer of its item.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last)
        else $error("block_done without last");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown after reset");

    a_rst_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_symbol))
        else $error("stalled result changed");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.symbol),
    .i_out_last   (o_out.last),
    .i_out_done   (o_out.block_done)
);

@@ test/tb_huffman_tree_decoder.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for huffman_tree_decoder: directed and random blocks of
// start, leaf and stream transfers, checked against a behavioural tree decoder.
// Depends on htd_pkg, htd_if and the decoder RTL.
module tb_huffman_tree_decoder;

    localparam int LEAF_LIMIT = 256;
    localparam int NODE_LIMIT = 511;

    // Behavioural decoder and store of symbols still to arrive.
    class symbol_scoreboard;
        logic [htd_pkg::FREQ_W-1:0]   freq [NODE_LIMIT];
        logic [htd_pkg::SYM_W-1:0]    leaf_sym [LEAF_LIMIT];
        int unsigned                  left_of [NODE_LIMIT];
        int unsigned                  right_of [NODE_LIMIT];
        int unsigned                  order [LEAF_LIMIT + 1];
        int unsigned                  loaded;
        int unsigned                  n_leaves;
        int unsigned                  root;
        int unsigned                  walk;
        logic [htd_pkg::COUNT_W-1:0]  remaining;
        htd_pkg::t_res                pending_syms [$];
        int unsigned                  errors;

        function void clear();
            loaded = 0;
            n_leaves = 0;
            root = 0;
            walk = 0;
            remaining = '0;
            errors = 0;
        endfunction

        function void build_tree();
            int unsigned cnt, nxt, l, r, p, pos, j;
            logic [htd_pkg::FREQ_W:0] sum;
            cnt = n_leaves;
            nxt = n_leaves;
            for (j = 0; j < n_leaves; j++) order[j] = j;
            while (cnt > 1 && nxt < NODE_LIMIT) begin
                l = order[cnt-1];
                r = order[cnt-2];
                p = nxt;
                nxt++;
                cnt -= 2;
                left_of[p] = l;
                right_of[p] = r;
                sum = {1'b0, freq[l]} + {1'b0, freq[r]};
                freq[p] = sum[htd_pkg::FREQ_W] ? '1 : sum[htd_pkg::FREQ_W-1:0];
                pos = cnt;
                while (pos > 0 && freq[order[pos-1]] < freq[p]) pos--;
                for (j = cnt; j > pos; j--) order[j] = order[j-1];
                order[pos] = p;
                cnt++;
            end
            root = order[0];
            walk = root;
        endfunction

        function void note_input(htd_pkg::t_action act,
                                 logic [htd_pkg::COUNT_W-1:0] count,
                                 logic [htd_pkg::LCOUNT_W-1:0] lcount,
                                 logic [htd_pkg::SYM_W-1:0] sym,
                                 logic [htd_pkg::LFREQ_W-1:0] lfreq,
                                 logic [htd_pkg::BYTE_W-1:0] bits);
            int unsigned n, b, w, made;
            htd_pkg::t_res r;
            made = 0;
            case (act)
                htd_pkg::ACT_START: begin
                    n = lcount;
                    if (n == 0) n = 1;
                    if (n > LEAF_LIMIT) n = LEAF_LIMIT;
                    n_leaves = n;
                    loaded = 0;
                    remaining = count;
                    root = 0;
                    walk = 0;
                end
                htd_pkg::ACT_LEAF: begin
                    if (loaded < n_leaves) begin
                        leaf_sym[loaded] = sym;
                        freq[loaded] = {1'b0, lfreq};
                        loaded++;
                        if (loaded == n_leaves) build_tree();
                    end
                end
                htd_pkg::ACT_STREAM: begin
                    if (n_leaves != 0 && loaded == n_leaves) begin
                        for (b = 0; b < 8 && remaining != 0; b++) begin
                            if (n_leaves == 1) begin
                                r.symbol = leaf_sym[0];
                            end else begin
                                w = (walk >= NODE_LIMIT) ? root : walk;
                                w = bits[b] ? right_of[w] : left_of[w];
                                if (w >= n_leaves) begin
                                    walk = w;
                                    continue;
                                end
                                r.symbol = leaf_sym[w];
                                walk = root;
                            end
                            remaining--;
                            r.last = 1'b0;
                            r.block_done = (remaining == 0);
                            pending_syms.push_back(r);
                            made++;
                        end
                        if (made > 0) pending_syms[pending_syms.size()-1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(htd_pkg::t_res got);
            htd_pkg::t_res want;
            if (pending_syms.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected symbol %02h last %b done %b",
                             got.symbol, got.last, got.block_done);
                return;
            end
            want = pending_syms.pop_front();
            if (got.symbol !== want.symbol || got.last !== want.last ||
                got.block_done !== want.block_done) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected sym %02h last %b done %b, got %02h %b %b",
                             want.symbol, want.last, want.block_done,
                             got.symbol, got.last, got.block_done);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    htd_in_if  in_ch ();
    htd_out_if out_ch ();

    huffman_tree_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    symbol_scoreboard sb;
    int unsigned tx_idle;
    int unsigned rx_idle;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned sent;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("tb_huffman_tree_decoder: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 400;
            hold_req <= 1'b0;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= (hold_left == 1);
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{symbol: out_ch.symbol, last: out_ch.last,
                              block_done: out_ch.block_done});
    end

    task automatic send(htd_pkg::t_action act, logic [htd_pkg::COUNT_W-1:0] count,
                        logic [htd_pkg::LCOUNT_W-1:0] lcount,
                        logic [htd_pkg::SYM_W-1:0] sym,
                        logic [htd_pkg::LFREQ_W-1:0] lfreq,
                        logic [htd_pkg::BYTE_W-1:0] bits);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.symbol_count <= count;
        in_ch.leaf_count <= lcount;
        in_ch.leaf_symbol <= sym;
        in_ch.leaf_frequency <= lfreq;
        in_ch.stream_byte <= bits;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(act, count, lcount, sym, lfreq, bits);
        sent++;
    endtask

    task automatic start_block(logic [htd_pkg::COUNT_W-1:0] count,
                               logic [htd_pkg::LCOUNT_W-1:0] lcount);
        send(htd_pkg::ACT_START, count, lcount, htd_pkg::SYM_W'($urandom),
             htd_pkg::LFREQ_W'($urandom), htd_pkg::BYTE_W'($urandom));
    endtask

    task automatic leaf(logic [htd_pkg::SYM_W-1:0] sym,
                        logic [htd_pkg::LFREQ_W-1:0] lfreq);
        send(htd_pkg::ACT_LEAF, $urandom, htd_pkg::LCOUNT_W'($urandom), sym, lfreq,
             htd_pkg::BYTE_W'($urandom));
    endtask

    task automatic stream(logic [htd_pkg::BYTE_W-1:0] bits);
        send(htd_pkg::ACT_STREAM, $urandom, htd_pkg::LCOUNT_W'($urandom),
             htd_pkg::SYM_W'($urandom), htd_pkg::LFREQ_W'($urandom), bits);
    endtask

    // One well-formed block with random content; odd ones get noise or bad order.
    task automatic random_block();
        int unsigned n, k, extra;
        logic [htd_pkg::LFREQ_W-1:0] f;
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
        start_block($urandom_range(1, 30), htd_pkg::LCOUNT_W'(n));
        f = htd_pkg::LFREQ_W'($urandom);
        if (f == 0) f = 1;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(5) == 0)
                leaf(htd_pkg::SYM_W'($urandom), htd_pkg::LFREQ_W'($urandom_range(1, 1000)));
            else leaf(htd_pkg::SYM_W'($urandom), f);
            if ($urandom_range(3) != 0)
                f = f - htd_pkg::LFREQ_W'($urandom_range(0, f / 2));
            if (f == 0) f = 1;
            if ($urandom_range(15) == 0)
                send(htd_pkg::t_action'(2'd3), $urandom, htd_pkg::LCOUNT_W'($urandom),
                     htd_pkg::SYM_W'($urandom), htd_pkg::LFREQ_W'($urandom),
                     htd_pkg::BYTE_W'($urandom));
        end
        extra = $urandom_range(2);
        while (sb.remaining != 0 || extra > 0) begin
            if (sb.remaining == 0) extra--;
            stream(htd_pkg::BYTE_W'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        tx_idle = 26;
        rx_idle = 79;
        hold_req = 1'b0;
        hold_left = 0;
        sent = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = htd_pkg::ACT_START;
        in_ch.symbol_count = '0;
        in_ch.leaf_count = '0;
        in_ch.leaf_symbol = '0;
        in_ch.leaf_frequency = '0;
        in_ch.stream_byte = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leaf and stream with no block open, and an unknown action: all ignored.
        leaf(8'h12, 31'd7);
        stream(8'hFF);
        send(htd_pkg::t_action'(2'd3), '1, '1, '1, '1, '1);
        // Leaf count zero is a single leaf: each byte gives eight copies.
        start_block(32'hFFFF_FFFF, 9'd0);
        leaf(8'hFF, 31'h7FFF_FFFF);
        stream(8'h00);
        stream(8'hFF);
        // Single leaf meeting its count mid-byte; the next byte is ignored.
        start_block(32'd5, 9'd1);
        leaf(8'h00, 31'd1);
        stream(8'h3C);
        stream(8'hC3);
        // Oversized leaf counts, each dropped by a fresh start.
        start_block(32'd3, 9'd300);
        leaf(8'h01, 31'd9);
        start_block(32'd3, 9'h1D0);
        // Saturating parent sum, then a leaf beyond the count.
        start_block(32'd20, 9'd3);
        leaf(8'hAA, 31'h7FFF_FFFF);
        leaf(8'h55, 31'h7FFF_FFFF);
        leaf(8'h0F, 31'h7FFF_FFFF);
        leaf(8'h77, 31'd1);
        stream(8'hFF);
        stream(8'hA5);
        // Leaves out of frequency order.
        start_block(32'd6, 9'd4);
        leaf(8'h10, 31'd1);
        leaf(8'h20, 31'd5);
        leaf(8'h30, 31'd9);
        leaf(8'h40, 31'd2);
        stream(8'h96);
        stream(8'h69);

        hold_req = 1'b1;
        while (sent < 50) random_block();
        tx_idle = 79;
        rx_idle = 26;
        while (sent < 72) random_block();
        tx_idle = 0;
        rx_idle = 0;
        while (sent < 90) random_block();
        in_ch.valid <= 1'b0;

        while (sb.pending_syms.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_syms.size() == 0) begin
            $display("tb_huffman_tree_decoder: PASS");
        end else begin
            $display("tb_huffman_tree_decoder: FAIL");
        end
        $finish;
    end
endmodule
